// ----- rtl/core/rdpc_pkg.sv -----
// Shared constants, state encoding and control/status structs for the
// running dominance pair counter. No dependencies.
package rdpc_pkg;

	localparam int MAX_ROOMS   = 1024;
	localparam int VALUE_BITS  = 30;
	localparam int HP_BITS     = 30;
	localparam int PREFIX_BITS = 40;
	localparam int SCORE_BITS  = 20;
	localparam int THR_BITS    = PREFIX_BITS + 2;
	localparam int CNT_BITS    = $clog2(MAX_ROOMS + 1);
	localparam int ADDR_BITS   = $clog2(MAX_ROOMS);
	localparam int IN_DATA_W   = ((2 * VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((SCORE_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/rdpc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rdpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/rdpc_ctrl.sv -----
// Controller state machine: accepts an item, sequences the prefix scan and
// commits the result. Depends on rdpc_pkg.
module rdpc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  rdpc_pkg::sts_t sts,
	output rdpc_pkg::cmd_t cmd
);
	import rdpc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.full || sts.empty) begin
						state_d = ST_UPDATE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/rdpc_dp.sv -----
// Datapath: run state, prefix store, scan compare, score and output register.
// Depends on rdpc_pkg and rdpc_ram.
module rdpc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rdpc_pkg::HP_BITS-1:0]       cfg_wdata,
	input  logic [rdpc_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rdpc_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast,
	input  rdpc_pkg::cmd_t                     cmd,
	output rdpc_pkg::sts_t                     sts
);
	import rdpc_pkg::*;

	logic [HP_BITS-1:0]     hp_q;
	logic [CNT_BITS-1:0]    b_q;
	logic [PREFIX_BITS-1:0] run_q;
	logic [SCORE_BITS-1:0]  failing_q;
	logic [SCORE_BITS-1:0]  pairs_q;
	logic [PREFIX_BITS-1:0] newp_q;
	logic signed [THR_BITS-1:0] thr_q;
	logic                   last_q;
	logic                   ovf_q;
	logic [SCORE_BITS-1:0]  fails_q;
	logic [ADDR_BITS-1:0]   scan_addr_q;
	logic                   rd_valid_s1;
	logic                   out_valid_q;
	logic [SCORE_BITS-1:0]  score_q;
	logic                   out_ovf_q;
	logic                   out_last_q;

	logic [VALUE_BITS-1:0]  dmg;
	logic [VALUE_BITS-1:0]  req;
	logic [PREFIX_BITS-1:0] newp;
	logic signed [THR_BITS-1:0] thr;
	logic [PREFIX_BITS-1:0] rdata;
	logic                   hit;
	logic                   zero_fail;
	logic [CNT_BITS-1:0]    b_next;
	logic [SCORE_BITS-1:0]  pairs_next;
	logic [SCORE_BITS-1:0]  failing_next;
	logic [ADDR_BITS-1:0]   last_addr;

	assign dmg  = s_tdata[VALUE_BITS-1:0];
	assign req  = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
	assign newp = run_q + PREFIX_BITS'(dmg);
	assign thr  = $signed(THR_BITS'(req)) - $signed(THR_BITS'(hp_q))
		+ $signed(THR_BITS'(newp));

	assign hit       = $signed({2'b00, rdata}) < thr_q;
	assign zero_fail = thr_q > 0;
	assign b_next    = b_q + CNT_BITS'(1);
	assign pairs_next   = pairs_q + SCORE_BITS'(b_next);
	assign failing_next = failing_q + fails_q + SCORE_BITS'(zero_fail);
	assign last_addr = ADDR_BITS'(b_q - CNT_BITS'(1));

	assign sts.full      = b_q == CNT_BITS'(MAX_ROOMS);
	assign sts.empty     = b_q == '0;
	assign sts.scan_last = scan_addr_q == last_addr;
	assign sts.out_free  = !out_valid_q || m_tready;

	rdpc_ram #(
		.WIDTH(PREFIX_BITS),
		.DEPTH(MAX_ROOMS)
	) u_store (
		.clk  (clk),
		.we   (cmd.commit && !ovf_q),
		.waddr(b_q[ADDR_BITS-1:0]),
		.wdata(newp_q),
		.raddr(scan_addr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q        <= '0;
			b_q         <= '0;
			run_q       <= '0;
			failing_q   <= '0;
			pairs_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				hp_q <= cfg_wdata;
			end
			rd_valid_s1 <= cmd.rd;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				if (last_q) begin
					b_q       <= '0;
					run_q     <= '0;
					failing_q <= '0;
					pairs_q   <= '0;
				end else if (!ovf_q) begin
					b_q       <= b_next;
					run_q     <= newp_q;
					failing_q <= failing_next;
					pairs_q   <= pairs_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			newp_q      <= newp;
			thr_q       <= thr;
			last_q      <= s_tlast;
			ovf_q       <= sts.full;
			fails_q     <= '0;
			scan_addr_q <= '0;
		end else begin
			if (cmd.rd) begin
				scan_addr_q <= scan_addr_q + ADDR_BITS'(1);
			end
			if (rd_valid_s1 && hit) begin
				fails_q <= fails_q + SCORE_BITS'(1);
			end
		end
		if (cmd.commit) begin
			out_ovf_q  <= ovf_q;
			out_last_q <= last_q;
			if (ovf_q) begin
				score_q <= pairs_q - failing_q;
			end else begin
				score_q <= pairs_next - failing_next;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(score_q);
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- rtl/core/running_dominance_pair_counter.sv -----
// Top level of the running dominance pair counter.
// The scan reads the b rooms stored in the run (1..MAX_ROOMS-1), then ST_DRAIN, ST_UPDATE;
// the first room of a run or a room that finds the store full goes from ST_IDLE to ST_UPDATE.
// No new item is accepted until its result commits; one store read per scan cycle.
// Reset clears the run state and hit_points; the prefix store needs no clearing pass.
// Depends on rdpc_pkg, rdpc_ctrl, rdpc_dp and rdpc_ram.
module running_dominance_pair_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rdpc_pkg::HP_BITS-1:0]    cfg_wdata,  // hit_points
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rdpc_pkg::IN_DATA_W-1:0]  s_tdata,    // damage, requirement
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rdpc_pkg::OUT_DATA_W-1:0] m_tdata,    // score
	output logic                            m_tuser,    // overflow
	output logic                            m_tlast
);
	import rdpc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rdpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	rdpc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	a_scan_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !sts.full && !sts.empty)
		else $error("scan issued with empty or full store");

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("result committed over a pending result");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !s_tready)
		else $error("input ready during scan");

endmodule
